// ===== rtl/core/abm_pkg.sv =====
// Shared types, codes and constants of the adjacency bit matrix.
`default_nettype none

package abm_pkg;

  localparam int unsigned ABM_MAX_NODES = 64;
  localparam int unsigned NODE_W        = 6;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned TYPE_W        = 2;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  // Request kinds carried in tuser.
  typedef enum logic [TYPE_W-1:0] {
    REQ_LINK  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_LIST  = 2'd2
  } abm_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR_A,
    ST_WR_B,
    ST_QUERY,
    ST_SCAN,
    ST_EMIT
  } abm_state_e;

  // One result word.
  typedef struct packed {
    logic              status;
    logic              linked;
    logic [NODE_W-1:0] neighbor;
    logic              neighbor_valid;
    logic              last;
  } abm_res_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic     valid;
    abm_res_t res;
  } abm_emit_t;

endpackage

`default_nettype wire

// ===== rtl/core/abm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module abm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/abm_seq.sv =====
// Request sequencer: row read-modify-write, query and neighbour row scan.
`default_nettype none

module abm_seq #(
  parameter int unsigned MAX_NODES = abm_pkg::ABM_MAX_NODES,
  localparam int unsigned AW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [abm_pkg::TYPE_W-1:0]   req_type_i,
  input  wire logic [abm_pkg::NODE_W-1:0]   node_a_i,
  input  wire logic [abm_pkg::NODE_W-1:0]   node_b_i,
  input  wire logic [abm_pkg::COUNT_W-1:0]  max_nbr_i,
  input  wire logic [abm_pkg::COUNT_W-1:0]  node_count_i,
  input  wire logic                         out_free_i,
  output abm_pkg::abm_emit_t                emit_o,
  output logic                              ram_we_o,
  output logic      [AW-1:0]                ram_waddr_o,
  output logic      [MAX_NODES-1:0]         ram_wdata_o,
  output logic                              ram_re_o,
  output logic      [AW-1:0]                ram_raddr_o,
  input  wire logic [MAX_NODES-1:0]         ram_rdata_i
);

  import abm_pkg::*;

  abm_state_e           state_q, state_d;
  logic [TYPE_W-1:0]    type_q, type_d;
  logic [NODE_W-1:0]    a_q, a_d, b_q, b_d;
  logic [COUNT_W-1:0]   maxn_q, maxn_d;
  logic [COUNT_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0]   found_q, found_d;
  logic [NODE_W-1:0]    pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  abm_res_t             res_q, res_d;
  logic                 rvalid_q, rvalid_d;
  logic [MAX_NODES-1:0] row_valid_q, row_valid_d;

  logic [COUNT_W-1:0]   cnt;
  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] bit_a, bit_b;
  logic                 range_err;
  logic                 scan_done;
  abm_res_t             ok_res;

  // Counts above the matrix size act as the matrix size.
  assign cnt = (node_count_i > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count_i;

  // A row never written reads as empty.
  assign row = rvalid_q ? ram_rdata_i : '0;

  always_comb begin
    bit_a = '0;
    bit_b = '0;
    bit_a[a_q[AW-1:0]] = 1'b1;
    bit_b[b_q[AW-1:0]] = 1'b1;
  end

  assign range_err = ({1'b0, node_a_i} >= cnt) ||
                     ((req_type_i != REQ_LIST) && ({1'b0, node_b_i} >= cnt));
  assign scan_done = (idx_q == cnt) || (found_q == maxn_q);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    ok_res        = '0;
    ok_res.last   = 1'b1;
  end

  always_comb begin
    state_d      = state_q;
    type_d       = type_q;
    a_d          = a_q;
    b_d          = b_q;
    maxn_d       = maxn_q;
    idx_d        = idx_q;
    found_d      = found_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    res_d        = res_q;
    row_valid_d  = row_valid_q;
    emit_o       = '0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = a_q[AW-1:0];
    ram_wdata_o  = row | bit_b;
    ram_re_o     = 1'b0;
    ram_raddr_o  = a_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          type_d       = req_type_i;
          a_d          = node_a_i;
          b_d          = node_b_i;
          maxn_d       = max_nbr_i;
          idx_d        = '0;
          found_d      = '0;
          pend_valid_d = 1'b0;
          case (req_type_i)
            REQ_LINK, REQ_QUERY, REQ_LIST: begin
              if (range_err) begin
                res_d        = ok_res;
                res_d.status = 1'b1;
                state_d      = ST_EMIT;
              end else begin
                state_d = ST_RD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        ram_re_o = 1'b1;
        case (type_q)
          REQ_LINK:  state_d = ST_WR_A;
          REQ_QUERY: state_d = ST_QUERY;
          default:   state_d = ST_SCAN;
        endcase
      end
      ST_WR_A: begin
        // write row a and fetch row b in the same cycle
        ram_we_o    = 1'b1;
        ram_waddr_o = a_q[AW-1:0];
        ram_wdata_o = row | bit_b;
        row_valid_d[a_q[AW-1:0]] = 1'b1;
        ram_re_o    = 1'b1;
        ram_raddr_o = b_q[AW-1:0];
        state_d     = ST_WR_B;
      end
      ST_WR_B: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = b_q[AW-1:0];
        ram_wdata_o = row | bit_a;
        row_valid_d[b_q[AW-1:0]] = 1'b1;
        res_d       = ok_res;
        state_d     = ST_EMIT;
      end
      ST_QUERY: begin
        res_d        = ok_res;
        res_d.linked = row[b_q[AW-1:0]];
        state_d      = ST_EMIT;
      end
      ST_SCAN: begin
        if (scan_done) begin
          res_d                = ok_res;
          res_d.neighbor       = pend_valid_q ? pend_q : '0;
          res_d.neighbor_valid = pend_valid_q;
          state_d              = ST_EMIT;
        end else if (row[idx_q[AW-1:0]]) begin
          // a new hit releases the previous one, which is then known not last
          if (!pend_valid_q || out_free_i) begin
            emit_o.valid              = pend_valid_q;
            emit_o.res.neighbor       = pend_q;
            emit_o.res.neighbor_valid = 1'b1;
            pend_d       = NODE_W'(idx_q);
            pend_valid_d = 1'b1;
            found_d      = found_q + 1'b1;
            idx_d        = idx_q + 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          emit_o.valid = 1'b1;
          emit_o.res   = res_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rvalid_d = ram_re_o ? row_valid_q[ram_raddr_o] : rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      row_valid_q  <= '0;
      rvalid_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      idx_q        <= '0;
      found_q      <= '0;
    end else begin
      state_q      <= state_d;
      row_valid_q  <= row_valid_d;
      rvalid_q     <= rvalid_d;
      pend_valid_q <= pend_valid_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    a_q    <= a_d;
    b_q    <= b_d;
    maxn_q <= maxn_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o.valid |-> out_free_i) else $error("result offered to a full output register");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_WR_A || state_q == ST_WR_B))
    else $error("row write outside a link");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= cnt)) else $error("scan ran past node count");

  a_found_le_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= idx_q) else $error("more hits than indices scanned");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o.valid && emit_o.res.last) |=> (state_q == ST_IDLE))
    else $error("final word did not end the request");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/adjacency_bit_matrix.sv =====
// Requests are handled one at a time; an unused kind is dropped. Out of range: status word
// with no row access. Query: row read. Link: row read, two row writes, hand-off. List: scan
// of row a, each hit's word released at the next hit, then a final word; output stalls add
// to all of these.
// Reset: link rows read as empty via per-row valid flops (no clearing pass),
// node_count returns to 64, output register empties.
`default_nettype none

module adjacency_bit_matrix #(
  parameter int unsigned MAX_NODES = abm_pkg::ABM_MAX_NODES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // node_a[5:0], node_b[11:6], max_neighbors[18:12]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // linked[0], neighbor[6:1]
  output logic [1:0]       m_axis_tuser,   // status[0], neighbor_valid[1]
  output logic             m_axis_tlast,   // last
  // node_count register write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);

  import abm_pkg::*;

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [COUNT_W-1:0]   node_count_q;
  logic                 m_valid_q;
  abm_res_t             m_res_q;
  logic                 out_free;
  abm_emit_t            emit;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [MAX_NODES-1:0] ram_wdata, ram_rdata;

  // Register writes must come only while the block is idle (unenforced); always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RESET;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // Output register: frees in the cycle its word is taken.
  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      m_res_q <= emit.res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_res_q.neighbor, m_res_q.linked};
  assign m_axis_tuser  = {m_res_q.neighbor_valid, m_res_q.status};
  assign m_axis_tlast  = m_res_q.last;

  abm_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .node_a_i     (s_axis_tdata[5:0]),
    .node_b_i     (s_axis_tdata[11:6]),
    .max_nbr_i    (s_axis_tdata[18:12]),
    .node_count_i (node_count_q),
    .out_free_i   (out_free),
    .emit_o       (emit),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  // One row of link bits per node.
  abm_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
